/* hw/rtl/bit_destuffing_frame_receiver_assert.svh */
// Assertion macros for the checker file of the frame receiver.
`ifndef BIT_DESTUFFING_FRAME_RECEIVER_ASSERT_SVH
`define BIT_DESTUFFING_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, sampled on clk, idle during reset
`define BDFR_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, idle during reset
`define BDFR_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/bdfr_pkg.sv */
package bdfr_pkg;

    // Reset values of the configuration registers
    localparam logic [7:0] FLAG_RESET  = 8'h7E;
    localparam logic [7:0] START_RESET = 8'h80;

    // Register indexes on the configuration port (paddr[2])
    localparam logic REG_FLAG  = 1'b0;
    localparam logic REG_START = 1'b1;

    // Destuffing: a zero after exactly this many ones is dropped
    localparam logic [2:0] STUFF_RUN = 3'd5;
    localparam logic [2:0] ONES_MAX  = 3'd6;

    // Bit queue between front and back
    localparam int BITQ_DEPTH = 4;
    localparam int BITQ_AW    = $clog2(BITQ_DEPTH);
    localparam int BITQ_CW    = $clog2(BITQ_DEPTH + 1);

    // Result queue at the output
    localparam int OUTQ_DEPTH = 2;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_HUNT     = 2'd0,
        MODE_GOT_FLAG = 2'd1,
        MODE_FRAME    = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        EV_FLAG  = 2'd0,
        EV_START = 2'd1,
        EV_DATA  = 2'd2,
        EV_END   = 2'd3
    } event_t;

    // One kept line bit travelling towards the deframer
    typedef struct packed {
        logic valid;
        logic value;
    } bit_item_t;

endpackage

/* hw/rtl/bdfr_front.sv */
module bdfr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                line_bit,
    output bdfr_pkg::bit_item_t kept
);

    logic [2:0] ones_run_reg;
    logic [2:0] ones_run_next;
    logic       stuffed;

    // Classify the incoming bit: drop a zero after exactly the stuff run
    assign stuffed = !line_bit && (ones_run_reg == bdfr_pkg::STUFF_RUN);

    always_comb
    begin
        ones_run_next = ones_run_reg;
        if (accept)
        begin
            if (line_bit)
            begin
                if (ones_run_reg < bdfr_pkg::ONES_MAX)
                begin
                    ones_run_next = ones_run_reg + 3'd1;
                end
            end
            else
            begin
                ones_run_next = 3'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ones_run_reg <= 3'd0;
        end
        else
        begin
            ones_run_reg <= ones_run_next;
        end
    end

    // Pass every non-stuffed bit on to the bit queue
    assign kept.valid = accept && !stuffed;
    assign kept.value = line_bit;

endmodule

/* hw/rtl/bdfr_bitq.sv */
module bdfr_bitq (
    input  logic                clk,
    input  logic                rst_n,
    input  bdfr_pkg::bit_item_t wr,
    output logic                full,
    output bdfr_pkg::bit_item_t rd,
    input  logic                rd_pop
);

    logic [bdfr_pkg::BITQ_DEPTH-1:0] bits_reg;
    logic [bdfr_pkg::BITQ_AW-1:0]    wr_ptr_reg;
    logic [bdfr_pkg::BITQ_AW-1:0]    rd_ptr_reg;
    logic [bdfr_pkg::BITQ_CW-1:0]    count_reg;
    logic [bdfr_pkg::BITQ_CW-1:0]    count_next;
    logic                            do_wr;
    logic                            do_rd;

    assign full  = (count_reg == bdfr_pkg::BITQ_CW'(bdfr_pkg::BITQ_DEPTH));
    assign do_wr = wr.valid && !full;
    assign do_rd = rd_pop && (count_reg != '0);

    assign rd.valid = (count_reg != '0);
    assign rd.value = bits_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + bdfr_pkg::BITQ_CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - bdfr_pkg::BITQ_CW'(1);
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + bdfr_pkg::BITQ_AW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + bdfr_pkg::BITQ_AW'(1);
            end
        end
    end

    // Hold the bit payload
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            bits_reg[wr_ptr_reg] <= wr.value;
        end
    end

endmodule

/* hw/rtl/bdfr_back.sv */
module bdfr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          flag_pattern,
    input  logic [7:0]          start_pattern,
    input  bdfr_pkg::bit_item_t bq,
    output logic                bq_pop,
    input  logic                pop,
    output logic                empty,
    output logic [1:0]          event_res,
    output logic [7:0]          data_byte
);

    logic [7:0]            shift_reg;
    logic [7:0]            shift_next;
    bdfr_pkg::mode_t       mode_reg;
    bdfr_pkg::mode_t       mode_next;
    logic [2:0]            bit_count_reg;
    logic [2:0]            bit_count_next;
    logic                  aligned;
    logic                  take;
    logic                  res_valid;
    bdfr_pkg::event_t      res_ev;

    bdfr_pkg::event_t              oq_ev_reg   [bdfr_pkg::OUTQ_DEPTH];
    logic [7:0]                    oq_data_reg [bdfr_pkg::OUTQ_DEPTH];
    logic [bdfr_pkg::OUTQ_AW-1:0]  oq_wr_ptr_reg;
    logic [bdfr_pkg::OUTQ_AW-1:0]  oq_rd_ptr_reg;
    logic [bdfr_pkg::OUTQ_CW-1:0]  oq_count_reg;
    logic [bdfr_pkg::OUTQ_CW-1:0]  oq_count_next;
    logic                          oq_full;
    logic                          oq_push;
    logic                          oq_pop;

    // Take a bit when the result queue has room or is being drained
    assign oq_full = (oq_count_reg == bdfr_pkg::OUTQ_CW'(bdfr_pkg::OUTQ_DEPTH));
    assign oq_pop  = pop && !empty;
    assign take    = bq.valid && (!oq_full || oq_pop);
    assign bq_pop  = take;

    assign shift_next = {shift_reg[6:0], bq.value};
    assign aligned    = (bit_count_reg == 3'd7);

    // Next state of the deframer
    always_comb
    begin
        mode_next      = mode_reg;
        bit_count_next = bit_count_reg;
        if (take)
        begin
            unique case (mode_reg)
                bdfr_pkg::MODE_GOT_FLAG:
                begin
                    bit_count_next = bit_count_reg + 3'd1;
                    if (aligned && (shift_next != flag_pattern))
                    begin
                        if (shift_next == start_pattern)
                        begin
                            mode_next = bdfr_pkg::MODE_FRAME;
                        end
                        else
                        begin
                            mode_next = bdfr_pkg::MODE_HUNT;
                        end
                    end
                end
                bdfr_pkg::MODE_FRAME:
                begin
                    bit_count_next = bit_count_reg + 3'd1;
                    if (aligned && (shift_next == flag_pattern))
                    begin
                        mode_next = bdfr_pkg::MODE_HUNT;
                    end
                end
                default:
                begin
                    if (shift_next == flag_pattern)
                    begin
                        bit_count_next = 3'd0;
                        mode_next      = bdfr_pkg::MODE_GOT_FLAG;
                    end
                end
            endcase
        end
    end

    // Results of the deframer
    always_comb
    begin
        res_valid = 1'b0;
        res_ev    = bdfr_pkg::EV_FLAG;
        if (take)
        begin
            unique case (mode_reg)
                bdfr_pkg::MODE_GOT_FLAG:
                begin
                    if (aligned && (shift_next != flag_pattern)
                        && (shift_next == start_pattern))
                    begin
                        res_valid = 1'b1;
                        res_ev    = bdfr_pkg::EV_START;
                    end
                end
                bdfr_pkg::MODE_FRAME:
                begin
                    if (aligned)
                    begin
                        res_valid = 1'b1;
                        res_ev    = (shift_next == flag_pattern) ? bdfr_pkg::EV_END
                                                                 : bdfr_pkg::EV_DATA;
                    end
                end
                default:
                begin
                    if (shift_next == flag_pattern)
                    begin
                        res_valid = 1'b1;
                        res_ev    = bdfr_pkg::EV_FLAG;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg     <= 8'd0;
            mode_reg      <= bdfr_pkg::MODE_HUNT;
            bit_count_reg <= 3'd0;
        end
        else
        begin
            if (take)
            begin
                shift_reg <= shift_next;
            end
            mode_reg      <= mode_next;
            bit_count_reg <= bit_count_next;
        end
    end

    // Result queue bookkeeping
    assign oq_push = take && res_valid;

    always_comb
    begin
        oq_count_next = oq_count_reg;
        if (oq_push && !oq_pop)
        begin
            oq_count_next = oq_count_reg + bdfr_pkg::OUTQ_CW'(1);
        end
        else if (oq_pop && !oq_push)
        begin
            oq_count_next = oq_count_reg - bdfr_pkg::OUTQ_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_ptr_reg <= '0;
            oq_rd_ptr_reg <= '0;
            oq_count_reg  <= '0;
        end
        else
        begin
            oq_count_reg <= oq_count_next;
            if (oq_push)
            begin
                oq_wr_ptr_reg <= oq_wr_ptr_reg + bdfr_pkg::OUTQ_AW'(1);
            end
            if (oq_pop)
            begin
                oq_rd_ptr_reg <= oq_rd_ptr_reg + bdfr_pkg::OUTQ_AW'(1);
            end
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_ev_reg[oq_wr_ptr_reg]   <= res_ev;
            oq_data_reg[oq_wr_ptr_reg] <= shift_next;
        end
    end

    assign empty     = (oq_count_reg == '0);
    assign event_res = oq_ev_reg[oq_rd_ptr_reg];
    assign data_byte = oq_data_reg[oq_rd_ptr_reg];

endmodule

/* hw/rtl/bit_destuffing_frame_receiver.sv */
// A kept bit is registered in the bit queue; its result is registered in the result queue.
// Throughput: one line bit per cycle while the four-entry bit queue has room; the deframer takes
// one kept bit per cycle and stalls only while the two-entry result queue is full and not popped.
// Reset (rst_n low, asynchronous): queues empty, hunting for a flag, counters and shift
// register cleared, flag_pattern 0x7E and start_pattern 0x80.
module bit_destuffing_frame_receiver (
    input  logic        clk,
    input  logic        rst_n,
    // Line bit input
    input  logic        push,
    output logic        full,
    input  logic        line_bit,
    // Result output
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  event_res,
    output logic [7:0]  data_byte,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]          flag_pattern_reg;
    logic [7:0]          start_pattern_reg;
    logic                cfg_wr;
    logic                in_accept;
    logic                bq_full;
    logic                bq_pop;
    bdfr_pkg::bit_item_t kept;
    bdfr_pkg::bit_item_t bq_head;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_pattern_reg  <= bdfr_pkg::FLAG_RESET;
            start_pattern_reg <= bdfr_pkg::START_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                bdfr_pkg::REG_FLAG:  flag_pattern_reg  <= pwdata[7:0];
                bdfr_pkg::REG_START: start_pattern_reg <= pwdata[7:0];
                default:             flag_pattern_reg  <= flag_pattern_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            bdfr_pkg::REG_FLAG:  prdata = {24'd0, flag_pattern_reg};
            bdfr_pkg::REG_START: prdata = {24'd0, start_pattern_reg};
            default:             prdata = 32'd0;
        endcase
    end

    // Accept line bits while the bit queue has room
    assign full      = bq_full;
    assign in_accept = push && !bq_full;

    bdfr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (in_accept),
        .line_bit (line_bit),
        .kept     (kept)
    );

    bdfr_bitq u_bitq (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (kept),
        .full   (bq_full),
        .rd     (bq_head),
        .rd_pop (bq_pop)
    );

    bdfr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .flag_pattern  (flag_pattern_reg),
        .start_pattern (start_pattern_reg),
        .bq            (bq_head),
        .bq_pop        (bq_pop),
        .pop           (pop),
        .empty         (empty),
        .event_res     (event_res),
        .data_byte     (data_byte)
    );

endmodule

/* hw/rtl/bdfr_checker.sv */
`include "bit_destuffing_frame_receiver_assert.svh"

module bdfr_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        empty,
    input  logic        pop,
    input  logic [1:0]  event_res,
    input  logic [7:0]  data_byte,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready
);

    // A waiting item that is not popped stays put
    `BDFR_ASSERT_NEXT(a_out_hold, !empty && !pop, !empty && $stable(event_res) && $stable(data_byte), "result item changed while stalled")

    // The configuration port never inserts wait states
    `BDFR_ASSERT_NOW(a_pready_high, 1'b1, pready, "pready dropped")

    // A written flag pattern reads back on the next cycle
    `BDFR_ASSERT_NEXT(a_flag_readback, psel && penable && pwrite && !paddr[2], paddr[2] || (prdata[7:0] == $past(pwdata[7:0])), "flag pattern readback mismatch")

    // Registers are 8 bits wide: upper read data is zero
    `BDFR_ASSERT_NOW(a_prdata_upper, 1'b1, prdata[31:8] == 24'd0, "upper read data not zero")

endmodule

bind bit_destuffing_frame_receiver bdfr_checker u_bdfr_checker (.*);

/* verif/bit_destuffing_frame_receiver_test.sv */
`timescale 1ns / 100ps

module bit_destuffing_frame_receiver_test;

    localparam int BYTE_BITS     = 8;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 120;
    localparam int PHASE_BITS    = 120;
    localparam int TIMEOUT_NS    = 5_000_000;

    // One row of the directed table: a run of line bits sent MSB first, with the
    // event of the last bit typed in where it is obvious
    typedef struct packed {
        logic [4:0]       nbits;
        logic [15:0]      pattern;
        logic             typed;
        logic             has;
        bdfr_pkg::event_t ev;
        logic [7:0]       val;
    } stim_row_t;

    typedef struct packed {
        bdfr_pkg::event_t ev;
        logic [7:0]       val;
    } deframed_t;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        push    = 1'b0;
    logic        line_bit = 1'b0;
    logic        pop     = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic        full;
    logic        empty;
    logic [1:0]  event_res;
    logic [7:0]  data_byte;
    logic [31:0] prdata;
    logic        pready;

    // Deframer state as the block should hold it
    logic [7:0]      rx_shift  = 8'h00;
    bdfr_pkg::mode_t rx_mode   = bdfr_pkg::MODE_HUNT;
    logic [3:0]      rx_count  = 4'd0;
    logic [2:0]      rx_ones   = 3'd0;
    logic [7:0]      flag_cfg  = bdfr_pkg::FLAG_RESET;
    logic [7:0]      start_cfg = bdfr_pkg::START_RESET;

    deframed_t   expected_events [$];
    stim_row_t   row_now;
    logic        row_typed = 1'b0;
    logic        hold_req  = 1'b0;
    logic        tx_steady = 1'b0;
    logic [2:0]  tx_ones   = 3'd0;
    int unsigned bits_sent      = 0;
    int unsigned events_checked = 0;
    int unsigned mismatches     = 0;

    stim_row_t directed_rows [10] = '{
        // flag straight after reset
        '{5'd8,  16'h007E, 1'b1, 1'b1, bdfr_pkg::EV_FLAG,  8'h7E},
        // repeated flag while waiting: nothing, alignment restarts
        '{5'd8,  16'h007E, 1'b1, 1'b0, bdfr_pkg::EV_FLAG,  8'h00},
        '{5'd8,  16'h0080, 1'b1, 1'b1, bdfr_pkg::EV_START, 8'h80},
        // five ones then a stuffed zero, which is dropped
        '{5'd9,  16'h01F0, 1'b1, 1'b1, bdfr_pkg::EV_DATA,  8'hF8},
        '{5'd8,  16'h0000, 1'b1, 1'b1, bdfr_pkg::EV_DATA,  8'h00},
        // long run of ones saturates the counter
        '{5'd8,  16'h00FF, 1'b1, 1'b1, bdfr_pkg::EV_DATA,  8'hFF},
        // zero after six ones is kept, so the flag closes the frame
        '{5'd8,  16'h007E, 1'b1, 1'b1, bdfr_pkg::EV_END,   8'h7E},
        '{5'd8,  16'h007E, 1'b1, 1'b1, bdfr_pkg::EV_FLAG,  8'h7E},
        // unexpected byte while waiting: back to hunting
        '{5'd8,  16'h0055, 1'b1, 1'b0, bdfr_pkg::EV_FLAG,  8'h00},
        // flag found off byte alignment
        '{5'd11, 16'h057E, 1'b0, 1'b0, bdfr_pkg::EV_FLAG,  8'h00}
    };

    bit_destuffing_frame_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .line_bit  (line_bit),
        .empty     (empty),
        .pop       (pop),
        .event_res (event_res),
        .data_byte (data_byte),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    // Advance the deframer by one line bit; returns 1 when the bit gives an event
    function automatic logic deframe_bit(input logic b, output bdfr_pkg::event_t ev,
                                         output logic [7:0] val);
        ev = bdfr_pkg::EV_FLAG;
        // drop a zero that follows exactly a stuffing run of ones
        if (b) begin
            if (rx_ones < bdfr_pkg::ONES_MAX)
                rx_ones = rx_ones + 3'd1;
        end
        else begin
            if (rx_ones == bdfr_pkg::STUFF_RUN) begin
                rx_ones = 3'd0;
                val = rx_shift;
                return 1'b0;
            end
            rx_ones = 3'd0;
        end
        rx_shift = {rx_shift[6:0], b};
        val = rx_shift;
        case (rx_mode)
            bdfr_pkg::MODE_GOT_FLAG:
            begin
                rx_count = rx_count + 4'd1;
                if (rx_count >= BYTE_BITS) begin
                    rx_count = 4'd0;
                    if (rx_shift == flag_cfg)
                        return 1'b0;
                    if (rx_shift == start_cfg) begin
                        rx_mode = bdfr_pkg::MODE_FRAME;
                        ev = bdfr_pkg::EV_START;
                        return 1'b1;
                    end
                    rx_mode = bdfr_pkg::MODE_HUNT;
                end
                return 1'b0;
            end
            bdfr_pkg::MODE_FRAME:
            begin
                rx_count = rx_count + 4'd1;
                if (rx_count >= BYTE_BITS) begin
                    rx_count = 4'd0;
                    if (rx_shift == flag_cfg) begin
                        rx_mode = bdfr_pkg::MODE_HUNT;
                        ev = bdfr_pkg::EV_END;
                    end
                    else begin
                        ev = bdfr_pkg::EV_DATA;
                    end
                    return 1'b1;
                end
                return 1'b0;
            end
            default:
            begin
                // hunt: compare at every bit position
                if (rx_shift == flag_cfg) begin
                    rx_count = 4'd0;
                    rx_mode = bdfr_pkg::MODE_GOT_FLAG;
                    ev = bdfr_pkg::EV_FLAG;
                    return 1'b1;
                end
                return 1'b0;
            end
        endcase
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Check results popped and predict for items pushed at this edge
    always @(posedge clk) begin : scoreboard
        deframed_t want;
        deframed_t next_ev;
        logic      hit;
        if (rst_n) begin
            if (pop && !empty) begin
                if (expected_events.size() == 0) begin
                    $error("result with none pending: event_res=%0d data_byte=%02h",
                           event_res, data_byte);
                    mismatches++;
                end
                else begin
                    want = expected_events.pop_front();
                    if (event_res !== want.ev) begin
                        $error("event_res: expected %0d, got %0d", want.ev, event_res);
                        mismatches++;
                    end
                    if (data_byte !== want.val) begin
                        $error("data_byte: expected %02h, got %02h", want.val, data_byte);
                        mismatches++;
                    end
                end
                events_checked++;
            end
            if (push && !full) begin
                hit = deframe_bit(line_bit, next_ev.ev, next_ev.val);
                if (row_typed) begin
                    if (row_now.has) begin
                        next_ev.ev  = row_now.ev;
                        next_ev.val = row_now.val;
                        expected_events.push_back(next_ev);
                    end
                end
                else if (hit) begin
                    expected_events.push_back(next_ev);
                end
            end
        end
    end

    // Offer one line bit, optionally after a gap, and hold it until taken
    task automatic send_bit(input logic b, input logic typed);
        if (!tx_steady && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat (pick_gap()) @(negedge clk);
        end
        row_typed = typed;
        push     <= 1'b1;
        line_bit <= b;
        do @(posedge clk); while (full !== 1'b0);
        bits_sent++;
        if (b) begin
            if (tx_ones < bdfr_pkg::ONES_MAX)
                tx_ones = tx_ones + 3'd1;
        end
        else begin
            tx_ones = 3'd0;
        end
        @(negedge clk);
    endtask

    // Send a byte MSB first, inserting a zero after each stuffing run when asked
    task automatic send_byte(input logic [7:0] v, input logic stuff);
        int i;
        for (i = BYTE_BITS - 1; i >= 0; i--) begin
            send_bit(v[i], 1'b0);
            if (stuff && tx_ones == bdfr_pkg::STUFF_RUN)
                send_bit(1'b0, 1'b0);
        end
    endtask

    task automatic send_noise(input int unsigned n);
        repeat (n) send_bit($urandom_range(0, 1), 1'b0);
    endtask

    // Flag, optional repeated flag, opener, stuffed payload, closing flag;
    // now and then a wrong opener or a cut-off byte
    task automatic send_frame();
        int unsigned n;
        logic [7:0]  d;
        if ($urandom_range(0, 4) == 0)
            tx_steady = !tx_steady;
        send_byte(flag_cfg, 1'b0);
        if ($urandom_range(0, 3) == 0)
            send_byte(flag_cfg, 1'b0);
        if ($urandom_range(0, 7) == 0)
            send_byte($urandom_range(0, 255), 1'b0);
        else
            send_byte(start_cfg, 1'b0);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
        repeat (n) begin
            d = $urandom_range(0, 255);
            if ($urandom_range(0, 7) == 0)
                d = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            send_byte(d, 1'b1);
        end
        if ($urandom_range(0, 7) == 0)
            send_noise($urandom_range(1, 7));
        send_byte(flag_cfg, 1'b0);
    endtask

    task automatic run_random(input int unsigned quota);
        int unsigned stop_at;
        stop_at = bits_sent + quota;
        while (bits_sent < stop_at) begin
            if ($urandom_range(0, 4) == 0)
                send_noise($urandom_range(1, 24));
            else
                send_frame();
        end
    endtask

    // Stop offering bits, wait for every pending event, then let the bit queue empty
    task automatic drain_block();
        push <= 1'b0;
        while (expected_events.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write one pattern register, then read it back
    task automatic write_reg(input logic idx, input logic [7:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h0, v};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == bdfr_pkg::REG_FLAG)
            flag_cfg = v;
        else
            start_cfg = v;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[7:0] !== v) begin
            $error("%s: expected %02h, got %02h",
                   (idx == bdfr_pkg::REG_FLAG) ? "flag_pattern" : "start_pattern",
                   v, prdata[7:0]);
            mismatches++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_patterns(input logic [7:0] flag_v, input logic [7:0] start_v);
        drain_block();
        write_reg(bdfr_pkg::REG_FLAG, flag_v);
        write_reg(bdfr_pkg::REG_START, start_v);
    endtask

    // Reset, directed table, then random phases under several pattern settings
    initial begin : stimulus
        int i;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[r]) begin
            row_now = directed_rows[r];
            for (i = row_now.nbits - 1; i >= 0; i--)
                send_bit(row_now.pattern[i], row_now.typed && i == 0);
        end

        hold_req = 1'b1;
        run_random(PHASE_BITS);
        set_patterns(8'h00, 8'hFF);
        run_random(PHASE_BITS);
        set_patterns(8'hFF, 8'h00);
        hold_req = 1'b1;
        run_random(PHASE_BITS);
        set_patterns($urandom_range(0, 255), $urandom_range(0, 255));
        run_random(PHASE_BITS);
        set_patterns(bdfr_pkg::FLAG_RESET, bdfr_pkg::START_RESET);
        run_random(PHASE_BITS);
        drain_block();

        $display("Sent %0d line bits, checked %0d events over five flag/start phases,",
                 bits_sent, events_checked);
        $display("with long receiver stalls and a full drain before each reconfiguration.");
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Pop with random gaps; hold off for a long stretch when asked
    initial begin : result_drain
        int unsigned idle_left;
        logic        steady;
        idle_left = 0;
        steady    = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (idle_left != 0) begin
                pop <= 1'b0;
                idle_left--;
            end
            else begin
                pop <= 1'b1;
                if ($urandom_range(0, 99) == 0)
                    steady = !steady;
                if (!steady && $urandom_range(0, 3) == 0)
                    idle_left = pick_gap();
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

endmodule
